// ===== sv/indexed_list_insert_remove_unit_assert.svh =====
// assertion macros for the indexed list unit
`ifndef INDEXED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ILRU_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ILRU_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== sv/ilru_pkg.sv =====
// shared types and constants of the indexed list unit
package ilru_pkg;

  localparam int IDX_BITS   = 7;
  localparam int VAL_BITS   = 32;
  localparam int COUNT_BITS = 7;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // what every cell does at the edge of an accepted transaction
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } act_t;

  typedef struct packed {
    act_t act;
    logic capture;
  } cell_ctrl_t;

endpackage

// ===== sv/indexed_list_insert_remove_unit.sv =====
// top level of the indexed list unit: request decode, cell chain, result gather
//
//  channel   direction  handshake        fields
//  request   in         start / busy     op, index, value
//  result    out        done (strobe)    data_out, count, status
//
// in every transaction the cells shift and capture the addressed word at
// the accept edge, the taps are gathered into the result register at the
// next edge; busy stays high until the result is gathered
// done is high for one cycle and the receiver cannot stall it
// rst is synchronous; it empties the list, cell contents stay undefined
module indexed_list_insert_remove_unit #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       op,
  input  logic [ilru_pkg::IDX_BITS-1:0]    index,
  input  logic [ilru_pkg::VAL_BITS-1:0]    value,
  output logic                             done,
  output logic [ilru_pkg::VAL_BITS-1:0]    data_out,
  output logic [ilru_pkg::COUNT_BITS-1:0]  count,
  output logic [1:0]                       status
);

  `include "indexed_list_insert_remove_unit_assert.svh"

  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int POS_BITS = (CNT_BITS > ilru_pkg::IDX_BITS) ? CNT_BITS : ilru_pkg::IDX_BITS;
  localparam logic [CNT_BITS-1:0] Full = CNT_BITS'(DEPTH);

  logic                  accept;
  ilru_pkg::op_t         op_in;
  logic [POS_BITS-1:0]   pos;
  logic [POS_BITS-1:0]   cnt_ext;
  logic [WORD_BITS-1:0]  val_w;
  ilru_pkg::cell_ctrl_t  ctrl;
  ilru_pkg::status_t     st_next;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [CNT_BITS-1:0]   cnt_next;
  logic                  ret_next;
  logic                  ret_q;
  ilru_pkg::status_t     st_q;
  logic [WORD_BITS-1:0]  gathered;

  logic [WORD_BITS-1:0]  words [DEPTH];
  logic [WORD_BITS-1:0]  taps  [DEPTH];

  assign accept  = start && !busy;
  assign op_in   = ilru_pkg::op_t'(op);
  assign pos     = POS_BITS'(index);
  assign cnt_ext = POS_BITS'(cnt_q);
  assign val_w   = WORD_BITS'(value);

  // request decode: status, new count and the action broadcast to the cells
  always_comb begin
    st_next  = ilru_pkg::ST_OK;
    cnt_next = cnt_q;
    ret_next = 1'b0;
    ctrl.act = ilru_pkg::ACT_HOLD;
    ctrl.capture = accept;
    unique case (op_in)
      ilru_pkg::OP_GET: begin
        if (pos >= cnt_ext) begin
          st_next = ilru_pkg::ST_RANGE;
        end else begin
          ret_next = 1'b1;
        end
      end
      ilru_pkg::OP_SET: begin
        if (pos > cnt_ext) begin
          st_next = ilru_pkg::ST_RANGE;
        end else if (pos == cnt_ext) begin
          if (cnt_q == Full) begin
            st_next = ilru_pkg::ST_FULL;
          end else begin
            ctrl.act = ilru_pkg::ACT_WRITE;
            cnt_next = cnt_q + 1'b1;
          end
        end else begin
          ctrl.act = ilru_pkg::ACT_WRITE;
          ret_next = 1'b1;
        end
      end
      ilru_pkg::OP_INSERT: begin
        if (pos > cnt_ext) begin
          st_next = ilru_pkg::ST_RANGE;
        end else if (cnt_q == Full) begin
          st_next = ilru_pkg::ST_FULL;
        end else begin
          ctrl.act = ilru_pkg::ACT_INSERT;
          cnt_next = cnt_q + 1'b1;
        end
      end
      ilru_pkg::OP_REMOVE: begin
        if (cnt_q == '0) begin
          st_next = ilru_pkg::ST_EMPTY;
        end else if (pos >= cnt_ext) begin
          st_next = ilru_pkg::ST_RANGE;
        end else begin
          ctrl.act = ilru_pkg::ACT_REMOVE;
          cnt_next = cnt_q - 1'b1;
          ret_next = 1'b1;
        end
      end
      default: begin
        st_next = ilru_pkg::ST_OK;
      end
    endcase
    if (!accept) begin
      ctrl.act = ilru_pkg::ACT_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] lower;
    logic [WORD_BITS-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = val_w;
    end else begin : g_mid_lo
      assign lower = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = words[i+1];
    end
    ilru_cell #(
      .WORD_BITS (WORD_BITS),
      .POS_BITS  (POS_BITS),
      .MY_POS    (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .pos   (pos),
      .value (val_w),
      .lower (lower),
      .upper (upper),
      .word  (words[i]),
      .tap   (taps[i])
    );
  end

  // at most one tap is non-zero, so an or over all of them picks it
  always_comb begin
    gathered = '0;
    for (int i = 0; i < DEPTH; i++) begin
      gathered = gathered | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt_q <= '0;
    end else begin
      done <= busy;
      busy <= accept;
      if (accept) begin
        cnt_q <= cnt_next;
      end
    end
    if (accept) begin
      ret_q <= ret_next;
      st_q  <= st_next;
    end
    if (busy) begin
      data_out <= ret_q ? ilru_pkg::VAL_BITS'(gathered) : '0;
      count    <= ilru_pkg::COUNT_BITS'(cnt_q);
      status   <= st_q;
    end
  end

  `ILRU_ASSERT_NEXT(a_accept_then_busy, accept, busy && !done, "accept not followed by busy")
  `ILRU_ASSERT_NOW(a_done_not_busy, done, !busy, "result strobe while busy")
  `ILRU_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= Full, "entry count beyond depth")
  `ILRU_ASSERT_NOW(a_fail_zero_data, done && status != ilru_pkg::ST_OK, data_out == '0, "failed transaction returned data")
  `ILRU_ASSERT_NOW(a_fail_keeps_count, done && status != ilru_pkg::ST_OK, cnt_q == $past(cnt_q, 2), "failed transaction changed count")

endmodule

// ===== sv/ilru_cell.sv =====
// one list slot: holds a word and shifts to or from its neighbours
module ilru_cell #(
  parameter int WORD_BITS = 32,
  parameter int POS_BITS  = 7,
  parameter int MY_POS    = 0
) (
  input  logic                  clk,
  input  ilru_pkg::cell_ctrl_t  ctrl,
  input  logic [POS_BITS-1:0]   pos,
  input  logic [WORD_BITS-1:0]  value,
  input  logic [WORD_BITS-1:0]  lower,
  input  logic [WORD_BITS-1:0]  upper,
  output logic [WORD_BITS-1:0]  word,
  output logic [WORD_BITS-1:0]  tap
);

  localparam logic [POS_BITS-1:0] MyPos = POS_BITS'(MY_POS);

  logic hit;
  logic above;

  assign hit   = (pos == MyPos);
  assign above = (MyPos > pos);

  always_ff @(posedge clk) begin
    unique case (ctrl.act)
      ilru_pkg::ACT_HOLD: begin
        word <= word;
      end
      ilru_pkg::ACT_WRITE: begin
        if (hit) begin
          word <= value;
        end
      end
      ilru_pkg::ACT_INSERT: begin
        if (hit) begin
          word <= value;
        end else if (above) begin
          word <= lower;
        end
      end
      ilru_pkg::ACT_REMOVE: begin
        if (hit || above) begin
          word <= upper;
        end
      end
      default: begin
        word <= word;
      end
    endcase
    // old word at the addressed slot, taken before any shift
    if (ctrl.capture) begin
      tap <= hit ? word : '0;
    end
  end

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the indexed list insert/remove unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 64;
  localparam int SLOT_BITS  = $clog2(LIST_DEPTH);

  typedef struct {
    logic [ilru_pkg::VAL_BITS-1:0]   data;
    logic [ilru_pkg::COUNT_BITS-1:0] count;
    ilru_pkg::status_t               status;
  } list_result_t;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  ilru_pkg::op_t                   op;
  logic [ilru_pkg::IDX_BITS-1:0]   index;
  logic [ilru_pkg::VAL_BITS-1:0]   value;
  logic                            done;
  logic [ilru_pkg::VAL_BITS-1:0]   data_out;
  logic [ilru_pkg::COUNT_BITS-1:0] count;
  logic [1:0]                      status;

  // shadow copy of the list, updated on every accepted transaction
  logic [ilru_pkg::VAL_BITS-1:0] list_words [0:LIST_DEPTH-1];
  int                            list_count;
  list_result_t                  pending_results [$];
  int                            mismatch_count;

  indexed_list_insert_remove_unit #(
    .DEPTH     (LIST_DEPTH),
    .WORD_BITS (32)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .index    (index),
    .value    (value),
    .done     (done),
    .data_out (data_out),
    .count    (count),
    .status   (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic list_result_t apply_list_request(
      ilru_pkg::op_t req_op,
      logic [ilru_pkg::IDX_BITS-1:0] idx,
      logic [ilru_pkg::VAL_BITS-1:0] val);
    list_result_t res;
    res.data   = '0;
    res.status = ilru_pkg::ST_OK;
    case (req_op)
      ilru_pkg::OP_GET: begin
        if (idx >= list_count) res.status = ilru_pkg::ST_RANGE;
        else res.data = list_words[SLOT_BITS'(idx)];
      end
      ilru_pkg::OP_SET: begin
        if (idx > list_count) begin
          res.status = ilru_pkg::ST_RANGE;
        end else if (idx == list_count) begin
          // set at the tail appends
          if (list_count >= LIST_DEPTH) begin
            res.status = ilru_pkg::ST_FULL;
          end else begin
            list_words[SLOT_BITS'(idx)] = val;
            list_count++;
          end
        end else begin
          res.data = list_words[SLOT_BITS'(idx)];
          list_words[SLOT_BITS'(idx)] = val;
        end
      end
      ilru_pkg::OP_INSERT: begin
        // range is tested before fullness
        if (idx > list_count) begin
          res.status = ilru_pkg::ST_RANGE;
        end else if (list_count >= LIST_DEPTH) begin
          res.status = ilru_pkg::ST_FULL;
        end else begin
          for (int k = list_count; k > idx; k--) begin
            list_words[SLOT_BITS'(k)] = list_words[SLOT_BITS'(k - 1)];
          end
          list_words[SLOT_BITS'(idx)] = val;
          list_count++;
        end
      end
      default: begin
        // emptiness is tested before range
        if (list_count == 0) begin
          res.status = ilru_pkg::ST_EMPTY;
        end else if (idx >= list_count) begin
          res.status = ilru_pkg::ST_RANGE;
        end else begin
          res.data = list_words[SLOT_BITS'(idx)];
          for (int k = idx; k + 1 < list_count; k++) begin
            list_words[SLOT_BITS'(k)] = list_words[SLOT_BITS'(k + 1)];
          end
          list_count--;
        end
      end
    endcase
    res.count = list_count[ilru_pkg::COUNT_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      pending_results.push_back(apply_list_request(op, index, value));
    end
  end

  // check every result strobe against the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, data_out", data_out, '0);
      end else begin
        want = pending_results.pop_front();
        if (data_out !== want.data) report_mismatch("data_out", data_out, want.data);
        if (count !== want.count) report_mismatch("count", 32'(count), 32'(want.count));
        if (status !== want.status) begin
          report_mismatch("status", 32'(status), 32'(want.status));
        end
      end
    end
  end

  task automatic send_request(ilru_pkg::op_t req_op, logic [ilru_pkg::IDX_BITS-1:0] idx,
                              logic [ilru_pkg::VAL_BITS-1:0] val, int idle_pct = 0);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    op    <= req_op;
    index <= idx;
    value <= val;
    do @(posedge clk); while (busy);
  endtask

  // hold off the sender until every outstanding transaction has completed
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [ilru_pkg::VAL_BITS-1:0] random_word();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  task automatic test_empty_list();
    drain_results();
    send_request(ilru_pkg::OP_GET, 7'd0, 32'h0000_0001);
    send_request(ilru_pkg::OP_REMOVE, 7'd0, '0);
    send_request(ilru_pkg::OP_REMOVE, 7'd127, '0);
    send_request(ilru_pkg::OP_SET, 7'd1, 32'hDEAD_BEEF);
    send_request(ilru_pkg::OP_INSERT, 7'd1, 32'hCAFE_F00D);
    send_request(ilru_pkg::OP_GET, 7'd64, '0);
  endtask

  task automatic test_basic_ops();
    send_request(ilru_pkg::OP_SET, 7'd0, 32'hFFFF_FFFF);
    send_request(ilru_pkg::OP_INSERT, 7'd0, 32'h0000_0000);
    send_request(ilru_pkg::OP_INSERT, 7'd2, 32'hA5A5_5A5A);
    send_request(ilru_pkg::OP_INSERT, 7'd1, 32'h8000_0001);
    for (int i = 0; i < 4; i++) begin
      send_request(ilru_pkg::OP_GET, i[ilru_pkg::IDX_BITS-1:0], '0);
    end
    send_request(ilru_pkg::OP_SET, 7'd2, 32'h1234_5678);
    send_request(ilru_pkg::OP_REMOVE, 7'd1, '0);
    send_request(ilru_pkg::OP_REMOVE, 7'd5, '0);
    send_request(ilru_pkg::OP_GET, 7'd3, '0);
    send_request(ilru_pkg::OP_REMOVE, 7'd0, '0);
    send_request(ilru_pkg::OP_REMOVE, 7'd0, '0);
    send_request(ilru_pkg::OP_REMOVE, 7'd0, '0);
    send_request(ilru_pkg::OP_REMOVE, 7'd0, '0);
  endtask

  task automatic test_full_list();
    int fill_from;
    drain_results();
    fill_from = list_count;
    for (int i = fill_from; i < LIST_DEPTH; i++) begin
      send_request(ilru_pkg::OP_SET, i[ilru_pkg::IDX_BITS-1:0], random_word());
    end
    send_request(ilru_pkg::OP_INSERT, 7'd0, 32'h1111_1111);
    send_request(ilru_pkg::OP_SET, 7'd64, 32'h2222_2222);
    send_request(ilru_pkg::OP_INSERT, 7'd65, 32'h3333_3333);
    send_request(ilru_pkg::OP_INSERT, 7'd64, 32'h4444_4444);
    send_request(ilru_pkg::OP_GET, 7'd63, '0);
    send_request(ilru_pkg::OP_GET, 7'd64, '0);
    send_request(ilru_pkg::OP_SET, 7'd63, 32'h5555_5555);
    send_request(ilru_pkg::OP_REMOVE, 7'd63, '0);
    send_request(ilru_pkg::OP_INSERT, 7'd63, 32'h6666_6666);
    send_request(ilru_pkg::OP_REMOVE, 7'd0, '0);
    send_request(ilru_pkg::OP_GET, 7'd127, '0);
  endtask

  // grow_pct steers the list towards full (high) or empty (low)
  task automatic random_request(int grow_pct, int idle_pct);
    int                            fill;
    int                            pick;
    logic [ilru_pkg::IDX_BITS-1:0] idx;
    fill = list_count;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      idx = ilru_pkg::IDX_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, 64));
      send_request(ilru_pkg::op_t'($urandom_range(0, 3)), idx, random_word(), idle_pct);
    end else if (pick < 8 + grow_pct) begin
      if ($urandom_range(0, 1) == 0) begin
        idx = ilru_pkg::IDX_BITS'($urandom_range(0, (fill > LIST_DEPTH) ? LIST_DEPTH : fill));
        send_request(ilru_pkg::OP_INSERT, idx, random_word(), idle_pct);
      end else begin
        send_request(ilru_pkg::OP_SET, fill[ilru_pkg::IDX_BITS-1:0], random_word(), idle_pct);
      end
    end else begin
      idx = (fill > 0) ? ilru_pkg::IDX_BITS'($urandom_range(0, fill - 1)) : '0;
      if (pick < 70) send_request(ilru_pkg::OP_REMOVE, idx, random_word(), idle_pct);
      else if (pick < 85) send_request(ilru_pkg::OP_GET, idx, random_word(), idle_pct);
      else send_request(ilru_pkg::OP_SET, idx, random_word(), idle_pct);
    end
  endtask

  task automatic test_random_traffic(int idle_pct);
    for (int blk = 0; blk < 4; blk++) begin
      for (int n = 0; n < 150; n++) random_request((blk % 2 == 0) ? 52 : 10, idle_pct);
      if (blk == 1) drain_results();
    end
    drain_results();
  endtask

  initial begin
    mismatch_count = 0;
    list_count     = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    op    <= ilru_pkg::OP_GET;
    index <= '0;
    value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_traffic(0);
    test_random_traffic(54);
    test_random_traffic(14);

    drain_results();
    if (mismatch_count == 0) begin
      $display("** indexed_list_insert_remove_unit: PASSED **");
    end else begin
      $display("** indexed_list_insert_remove_unit: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #500000;
    $display("** indexed_list_insert_remove_unit: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ilru_pkg.sv
sv/ilru_cell.sv
sv/indexed_list_insert_remove_unit.sv
dv/tb.sv
